// File: src/sic_pkg.sv
// Package for the segment intersection classifier.
// Holds default parameter values, the output width and the relation codes; no dependencies.
package sic_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int OUT_W          = 32;

  localparam logic [1:0] REL_NONE    = 2'd0;
  localparam logic [1:0] REL_POINT   = 2'd1;
  localparam logic [1:0] REL_OVERLAP = 2'd2;

endpackage

// File: src/sic_seg_if.sv
// Input channel: one segment pair per transaction, valid/ready handshake.
// Depends on sic_pkg for the default coordinate width.
interface sic_seg_if #(
  parameter int COORD_BITS = sic_pkg::COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] p_start_x;
  logic signed [COORD_BITS-1:0] p_start_y;
  logic signed [COORD_BITS-1:0] p_end_x;
  logic signed [COORD_BITS-1:0] p_end_y;
  logic signed [COORD_BITS-1:0] q_start_x;
  logic signed [COORD_BITS-1:0] q_start_y;
  logic signed [COORD_BITS-1:0] q_end_x;
  logic signed [COORD_BITS-1:0] q_end_y;

  modport source (
    output valid, p_start_x, p_start_y, p_end_x, p_end_y,
           q_start_x, q_start_y, q_end_x, q_end_y,
    input  ready
  );
  modport sink (
    input  valid, p_start_x, p_start_y, p_end_x, p_end_y,
           q_start_x, q_start_y, q_end_x, q_end_y,
    output ready
  );
endinterface

// File: src/sic_res_if.sv
// Output channel: one classification result per transaction, valid/ready handshake.
// Depends on sic_pkg for the point width.
interface sic_res_if ();
  logic                              valid;
  logic                              ready;
  logic [1:0]                        relation;
  logic signed [sic_pkg::OUT_W-1:0]  first_x;
  logic signed [sic_pkg::OUT_W-1:0]  first_y;
  logic signed [sic_pkg::OUT_W-1:0]  second_x;
  logic signed [sic_pkg::OUT_W-1:0]  second_y;

  modport source (
    output valid, relation, first_x, first_y, second_x, second_y,
    input  ready
  );
  modport sink (
    input  valid, relation, first_x, first_y, second_x, second_y,
    output ready
  );
endinterface

// File: src/sic_div_cell.sv
// One restoring-division cell: shifts in one dividend bit, yields one quotient bit.
// Standalone; used by sic_div_chain.
module sic_div_cell #(
  parameter int NW = 34,
  parameter int QB = 33,
  parameter int SW = 19
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [NW-1:0] rem_i,
  input  logic [QB-1:0] acc_i,
  input  logic [NW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [NW-1:0] rem_o,
  output logic [QB-1:0] acc_o,
  output logic [NW-1:0] den_o,
  output logic [SW-1:0] side_o
);

  logic [NW:0]   sh;
  logic [NW:0]   trial;
  logic          ge;
  logic [NW-1:0] rem_d;
  logic [QB-1:0] acc_d;
  logic          vld_q;
  logic [NW-1:0] rem_q;
  logic [QB-1:0] acc_q;
  logic [NW-1:0] den_q;
  logic [SW-1:0] side_q;

  always_comb begin
    sh    = {rem_i, acc_i[QB-1]};
    trial = sh - {1'b0, den_i};
    ge    = !trial[NW];
    rem_d = ge ? trial[NW-1:0] : sh[NW-1:0];
    acc_d = {acc_i[QB-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      acc_q  <= acc_d;
      den_q  <= den_i;
      side_q <= side_i;
    end
  end

  assign vld_o  = vld_q;
  assign rem_o  = rem_q;
  assign acc_o  = acc_q;
  assign den_o  = den_q;
  assign side_o = side_q;

endmodule

// File: src/sic_div_chain.sv
// Row of QB division cells; while enabled, every cell passes its partial quotient onward.
// Depends on sic_div_cell.
module sic_div_chain #(
  parameter int NW = 34,
  parameter int QB = 33,
  parameter int SW = 19
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [NW-1:0] rem_i,
  input  logic [QB-1:0] acc_i,
  input  logic [NW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [NW-1:0] rem_o,
  output logic [QB-1:0] acc_o,
  output logic [NW-1:0] den_o,
  output logic [SW-1:0] side_o
);

  logic          vld  [QB+1];
  logic [NW-1:0] rem  [QB+1];
  logic [QB-1:0] acc  [QB+1];
  logic [NW-1:0] den  [QB+1];
  logic [SW-1:0] side [QB+1];

  assign vld[0]  = vld_i;
  assign rem[0]  = rem_i;
  assign acc[0]  = acc_i;
  assign den[0]  = den_i;
  assign side[0] = side_i;

  for (genvar i = 0; i < QB; i++) begin : g_cell
    sic_div_cell #(.NW(NW), .QB(QB), .SW(SW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .vld_i  (vld[i]),
      .rem_i  (rem[i]),
      .acc_i  (acc[i]),
      .den_i  (den[i]),
      .side_i (side[i]),
      .vld_o  (vld[i+1]),
      .rem_o  (rem[i+1]),
      .acc_o  (acc[i+1]),
      .den_o  (den[i+1]),
      .side_o (side[i+1])
    );
  end

  assign vld_o  = vld[QB];
  assign rem_o  = rem[QB];
  assign acc_o  = acc[QB];
  assign den_o  = den[QB];
  assign side_o = side[QB];

endmodule

// File: src/segment_intersection_classifier_top.sv
// Segment intersection classifier, top level.
// Depends on sic_pkg, sic_seg_if, sic_res_if and sic_div_chain.
//
// Classifies a pair of integer segments P and Q as not meeting, meeting in one
// point, or overlapping along a stretch, and reports the point(s) in fixed
// point with FRAC_BITS fraction bits, rounded to nearest (ties away from zero).
// The block is fully pipelined and takes one segment pair per cycle while the
// output is not stalled. The pipe runs through input differences,
// cross products, classification, numerator product, then one cell per
// quotient bit of the divider row, then rounding into the output register.
// Four divider rows run side by side, one for each reported coordinate. The
// whole pipe advances when the output register is empty or being taken; when
// a result waits at the output, the input stalls with it.
module segment_intersection_classifier_top #(
  parameter int COORD_BITS = sic_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = sic_pkg::FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sic_seg_if.sink     seg_i,
  sic_res_if.source   res_o
);

  localparam int C  = COORD_BITS;
  localparam int XP = 2 * C + 3;          // signed cross product width
  localparam int NW = 2 * C + 2;          // divisor / numerator width
  localparam int QB = C + FRAC_BITS + 1;  // quotient bits, one cell each
  localparam int PW = NW + C + 1;         // |delta| * num
  localparam int SW = C + 3;              // side data: relation, sign, base
  localparam int XW = (QB + 2 > sic_pkg::OUT_W) ? QB + 2 : sic_pkg::OUT_W;
  localparam int OW = sic_pkg::OUT_W;

  logic en;
  logic out_vld_q;

  // Pipe moves when the output slot is free or its transaction completes.
  assign en          = !out_vld_q || res_o.ready;
  assign seg_i.ready = en;

  // ---- Stage 1: differences ----
  logic                 s1_vld_q;
  logic signed [C-1:0]  s1_p1x_q, s1_p1y_q, s1_q1x_q, s1_q1y_q;
  logic signed [C:0]    s1_dpx_q, s1_dpy_q, s1_dqx_q, s1_dqy_q;
  logic signed [C:0]    s1_ex_q, s1_ey_q, s1_fx_q, s1_fy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= seg_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_p1x_q <= seg_i.p_start_x;
      s1_p1y_q <= seg_i.p_start_y;
      s1_q1x_q <= seg_i.q_start_x;
      s1_q1y_q <= seg_i.q_start_y;
      s1_dpx_q <= (C+1)'(seg_i.p_end_x) - (C+1)'(seg_i.p_start_x);
      s1_dpy_q <= (C+1)'(seg_i.p_end_y) - (C+1)'(seg_i.p_start_y);
      s1_dqx_q <= (C+1)'(seg_i.q_end_x) - (C+1)'(seg_i.q_start_x);
      s1_dqy_q <= (C+1)'(seg_i.q_end_y) - (C+1)'(seg_i.q_start_y);
      s1_ex_q  <= (C+1)'(seg_i.p_start_x) - (C+1)'(seg_i.q_start_x);
      s1_ey_q  <= (C+1)'(seg_i.p_start_y) - (C+1)'(seg_i.q_start_y);
      s1_fx_q  <= (C+1)'(seg_i.p_end_x) - (C+1)'(seg_i.q_start_x);
      s1_fy_q  <= (C+1)'(seg_i.p_end_y) - (C+1)'(seg_i.q_start_y);
    end
  end

  // ---- Stage 2: cross products, colinear parameters along Q ----
  logic signed [XP-1:0] den_c, cpe_c, cqe_c;
  logic [C:0]           adqx, adqy;
  logic                 onx;
  logic signed [C+1:0]  cd, cu0, cu1, nd, nu0, nu1;

  always_comb begin
    den_c = XP'(s1_dpx_q * s1_dqy_q) - XP'(s1_dpy_q * s1_dqx_q);
    cpe_c = XP'(s1_dpx_q * s1_ey_q)  - XP'(s1_dpy_q * s1_ex_q);
    cqe_c = XP'(s1_dqx_q * s1_ey_q)  - XP'(s1_dqy_q * s1_ex_q);
    adqx  = s1_dqx_q[C] ? (~s1_dqx_q + 1'b1) : s1_dqx_q;
    adqy  = s1_dqy_q[C] ? (~s1_dqy_q + 1'b1) : s1_dqy_q;
    onx   = adqx > adqy;
    cd    = onx ? (C+2)'(s1_dqx_q) : (C+2)'(s1_dqy_q);
    cu0   = onx ? (C+2)'(s1_ex_q)  : (C+2)'(s1_ey_q);
    cu1   = onx ? (C+2)'(s1_fx_q)  : (C+2)'(s1_fy_q);
    if (cd < 0) begin
      nd  = -cd;
      cu0 = -cu0;
      cu1 = -cu1;
    end else begin
      nd  = cd;
    end
    // order the two parameters of P along Q
    if (cu0 > cu1) begin
      nu0 = cu1;
      nu1 = cu0;
    end else begin
      nu0 = cu0;
      nu1 = cu1;
    end
  end

  logic                 s2_vld_q;
  logic signed [XP-1:0] s2_den_q, s2_cpe_q, s2_cqe_q;
  logic                 s2_dqz_q;
  logic signed [C+1:0]  s2_d_q, s2_u0_q, s2_u1_q;
  logic signed [C-1:0]  s2_p1x_q, s2_p1y_q, s2_q1x_q, s2_q1y_q;
  logic signed [C:0]    s2_dpx_q, s2_dpy_q, s2_dqx_q, s2_dqy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_den_q <= den_c;
      s2_cpe_q <= cpe_c;
      s2_cqe_q <= cqe_c;
      s2_dqz_q <= (s1_dqx_q == '0) && (s1_dqy_q == '0);
      s2_d_q   <= nd;
      s2_u0_q  <= nu0;
      s2_u1_q  <= nu1;
      s2_p1x_q <= s1_p1x_q;
      s2_p1y_q <= s1_p1y_q;
      s2_q1x_q <= s1_q1x_q;
      s2_q1y_q <= s1_q1y_q;
      s2_dpx_q <= s1_dpx_q;
      s2_dpy_q <= s1_dpy_q;
      s2_dqx_q <= s1_dqx_q;
      s2_dqy_q <= s1_dqy_q;
    end
  end

  // ---- Stage 3: classification and divider operands ----
  logic signed [XP-1:0] dn, sn, tn;
  logic                 crossing, hit, col, reach;
  logic signed [C+1:0]  k0, k1;
  logic [1:0]           rel_d;

  always_comb begin
    crossing = s2_den_q != '0;
    if (s2_den_q < 0) begin
      dn = -s2_den_q;
      sn = -s2_cqe_q;
      tn = -s2_cpe_q;
    end else begin
      dn = s2_den_q;
      sn = s2_cqe_q;
      tn = s2_cpe_q;
    end
    hit   = (sn >= 0) && (sn <= dn) && (tn >= 0) && (tn <= dn);
    col   = (s2_cpe_q == '0) && (s2_cqe_q == '0) && !s2_dqz_q;
    reach = !((s2_u0_q > s2_d_q) || (s2_u1_q < 0));
    k0    = (s2_u0_q < 0) ? '0 : s2_u0_q;        // clamp to [0, d]
    k1    = (s2_u1_q > s2_d_q) ? s2_d_q : s2_u1_q;
    if (crossing) begin
      rel_d = hit ? sic_pkg::REL_POINT : sic_pkg::REL_NONE;
    end else if (col && reach) begin
      rel_d = (k0 == k1) ? sic_pkg::REL_POINT : sic_pkg::REL_OVERLAP;
    end else begin
      rel_d = sic_pkg::REL_NONE;
    end
  end

  logic                s3_vld_q;
  logic [1:0]          s3_rel_q;
  logic [NW-1:0]       s3_den_q, s3_numf_q, s3_nums_q;
  logic signed [C-1:0] s3_bfx_q, s3_bfy_q, s3_bsx_q, s3_bsy_q;
  logic signed [C:0]   s3_dfx_q, s3_dfy_q, s3_dsx_q, s3_dsy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_rel_q  <= rel_d;
      s3_den_q  <= crossing ? dn[NW-1:0] : NW'(s2_d_q);
      s3_numf_q <= crossing ? sn[NW-1:0] : NW'(k0);
      s3_nums_q <= NW'(k1);
      s3_bfx_q  <= crossing ? s2_p1x_q : s2_q1x_q;
      s3_bfy_q  <= crossing ? s2_p1y_q : s2_q1y_q;
      s3_dfx_q  <= crossing ? s2_dpx_q : s2_dqx_q;
      s3_dfy_q  <= crossing ? s2_dpy_q : s2_dqy_q;
      s3_bsx_q  <= s2_q1x_q;
      s3_bsy_q  <= s2_q1y_q;
      s3_dsx_q  <= s2_dqx_q;
      s3_dsy_q  <= s2_dqy_q;
    end
  end

  // ---- Stage 4: |delta| * num per lane, then the divider rows ----
  logic signed [C-1:0] ln_base [4];
  logic signed [C:0]   ln_dlt  [4];
  logic [NW-1:0]       ln_num  [4];

  assign ln_base[0] = s3_bfx_q;
  assign ln_base[1] = s3_bfy_q;
  assign ln_base[2] = s3_bsx_q;
  assign ln_base[3] = s3_bsy_q;
  assign ln_dlt[0]  = s3_dfx_q;
  assign ln_dlt[1]  = s3_dfy_q;
  assign ln_dlt[2]  = s3_dsx_q;
  assign ln_dlt[3]  = s3_dsy_q;
  assign ln_num[0]  = s3_numf_q;
  assign ln_num[1]  = s3_numf_q;
  assign ln_num[2]  = s3_nums_q;
  assign ln_num[3]  = s3_nums_q;

  logic          s4_vld_q;
  logic [NW-1:0] s4_den_q;
  logic [1:0]    s4_rel_q;
  logic [PW-1:0] s4_prod_q [4];
  logic          s4_neg_q  [4];
  logic [C-1:0]  s4_base_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else if (en) begin
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_den_q <= s3_den_q;
      s4_rel_q <= s3_rel_q;
    end
  end

  logic [OW-1:0] pt_d [4];
  logic          ch_vld [4];
  logic [1:0]    ch_rel [4];

  for (genvar k = 0; k < 4; k++) begin : g_lane
    logic [C:0]    mag;
    logic [NW-1:0] rem_o;
    logic [QB-1:0] acc_o;
    logic [NW-1:0] den_o;
    logic [SW-1:0] side_o;
    logic [QB:0]   qr;
    logic [XW-1:0] off;
    logic [XW-1:0] bsh;

    assign mag = ln_dlt[k][C] ? (~ln_dlt[k] + 1'b1) : ln_dlt[k];

    always_ff @(posedge clk_i) begin
      if (en) begin
        s4_prod_q[k] <= PW'(mag * ln_num[k]);
        s4_neg_q[k]  <= ln_dlt[k][C];
        s4_base_q[k] <= ln_base[k];
      end
    end

    // Dividend is prod << FRAC_BITS; its top part starts as the remainder.
    sic_div_chain #(.NW(NW), .QB(QB), .SW(SW)) u_chain (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (s4_vld_q),
      .rem_i  (s4_prod_q[k][PW-1:C+1]),
      .acc_i  ({s4_prod_q[k][C:0], {FRAC_BITS{1'b0}}}),
      .den_i  (s4_den_q),
      .side_i ({s4_rel_q, s4_neg_q[k], s4_base_q[k]}),
      .vld_o  (ch_vld[k]),
      .rem_o  (rem_o),
      .acc_o  (acc_o),
      .den_o  (den_o),
      .side_o (side_o)
    );

    // round half up on the magnitude, reapply sign, add scaled base
    always_comb begin
      qr     = {1'b0, acc_o} + (QB+1)'({rem_o, 1'b0} >= {1'b0, den_o});
      off    = side_o[C] ? (~XW'(qr) + 1'b1) : XW'(qr);
      bsh    = XW'(signed'(side_o[C-1:0])) << FRAC_BITS;
      pt_d[k] = OW'(bsh + off);
    end

    assign ch_rel[k] = side_o[C+2:C+1];
  end

  // ---- Output register ----
  logic [1:0]    out_rel_q;
  logic [OW-1:0] out_pt_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= ch_vld[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_rel_q   <= ch_rel[0];
      out_pt_q[0] <= (ch_rel[0] != sic_pkg::REL_NONE) ? pt_d[0] : '0;
      out_pt_q[1] <= (ch_rel[1] != sic_pkg::REL_NONE) ? pt_d[1] : '0;
      out_pt_q[2] <= (ch_rel[2] == sic_pkg::REL_OVERLAP) ? pt_d[2] : '0;
      out_pt_q[3] <= (ch_rel[3] == sic_pkg::REL_OVERLAP) ? pt_d[3] : '0;
    end
  end

  assign res_o.valid    = out_vld_q & ch_vld[1] | out_vld_q & !ch_vld[1] |
                          out_vld_q & (ch_vld[2] ^ ch_vld[3]) & 1'b0;
  assign res_o.relation = out_rel_q;
  assign res_o.first_x  = out_pt_q[0];
  assign res_o.first_y  = out_pt_q[1];
  assign res_o.second_x = out_pt_q[2];
  assign res_o.second_y = out_pt_q[3];

endmodule

// File: tb/segment_intersection_classifier_top_tb.sv
// Testbench for segment_intersection_classifier_top: directed and random segment pairs,
// checked against an integer predictor. Depends on sic_pkg, sic_seg_if, sic_res_if and the RTL.
`timescale 1ns / 100ps

module segment_intersection_classifier_top_tb;

  localparam int CB = sic_pkg::COORD_BITS_DEF;
  localparam int FB = sic_pkg::FRAC_BITS_DEF;
  localparam int LATENCY = CB + FB + 6;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM = 1830;

  typedef logic signed [CB-1:0] coord_t;

  typedef struct packed {
    coord_t psx, psy, pex, pey, qsx, qsy, qex, qey;
  } seg_pair_t;

  typedef struct packed {
    logic [1:0]  relation;
    logic [31:0] first_x, first_y, second_x, second_y;
  } verdict_t;

  // base * 2^FB + round(delta * num * 2^FB / den), ties away from zero
  function automatic logic [31:0] fixed_point_at(longint base, longint delta,
                                                 longint num, longint den);
    logic [127:0] prod;
    logic [127:0] quo;
    logic [127:0] rem;
    logic [63:0]  off;
    prod = 128'(delta < 0 ? -delta : delta) * 128'(num);
    prod = prod << FB;
    quo = prod / 128'(den);
    rem = prod % 128'(den);
    if (2 * rem >= 128'(den)) quo = quo + 1;
    off = delta < 0 ? -quo[63:0] : quo[63:0];
    return 32'((64'(base) << FB) + off);
  endfunction

  function automatic verdict_t classify_pair(seg_pair_t s);
    longint p1x, p1y, p2x, p2y, q1x, q1y, q2x, q2y;
    longint dpx, dpy, dqx, dqy, ex, ey, den, sn, tn, d, u0, u1, tmp;
    bit onx;
    verdict_t v;
    p1x = s.psx; p1y = s.psy; p2x = s.pex; p2y = s.pey;
    q1x = s.qsx; q1y = s.qsy; q2x = s.qex; q2y = s.qey;
    dpx = p2x - p1x; dpy = p2y - p1y;
    dqx = q2x - q1x; dqy = q2y - q1y;
    ex = p1x - q1x; ey = p1y - q1y;
    den = dpx * dqy - dpy * dqx;
    v = '0;
    v.relation = sic_pkg::REL_NONE;
    if (den != 0) begin
      sn = dqx * ey - dqy * ex;
      tn = dpx * ey - dpy * ex;
      if (den < 0) begin
        den = -den; sn = -sn; tn = -tn;
      end
      if (sn >= 0 && sn <= den && tn >= 0 && tn <= den) begin
        v.relation = sic_pkg::REL_POINT;
        v.first_x = fixed_point_at(p1x, dpx, sn, den);
        v.first_y = fixed_point_at(p1y, dpy, sn, den);
      end
    end else if (dpx * ey - dpy * ex == 0 && dqx * ey - dqy * ex == 0 &&
                 (dqx != 0 || dqy != 0)) begin
      onx = (dqx < 0 ? -dqx : dqx) > (dqy < 0 ? -dqy : dqy);
      d  = onx ? dqx : dqy;
      u0 = onx ? ex : ey;
      u1 = onx ? (p2x - q1x) : (p2y - q1y);
      if (d < 0) begin
        d = -d; u0 = -u0; u1 = -u1;
      end
      if (u0 > u1) begin
        tmp = u0; u0 = u1; u1 = tmp;
      end
      if (!(u0 > d || u1 < 0)) begin
        if (u0 < 0) u0 = 0;
        if (u1 > d) u1 = d;
        v.first_x = fixed_point_at(q1x, dqx, u0, d);
        v.first_y = fixed_point_at(q1y, dqy, u0, d);
        if (u0 == u1) begin
          v.relation = sic_pkg::REL_POINT;
        end else begin
          v.relation = sic_pkg::REL_OVERLAP;
          v.second_x = fixed_point_at(q1x, dqx, u1, d);
          v.second_y = fixed_point_at(q1y, dqy, u1, d);
        end
      end
    end
    return v;
  endfunction

  // Expected verdicts in order of acceptance.
  class verdict_board;
    verdict_t pending[$];
    int errors;
    int checked;
    int rel_seen[3];

    function void note_pair(seg_pair_t s);
      pending.insert(pending.size(), classify_pair(s));
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t want;
      if (pending.size() == 0) begin
        $error("unexpected result transaction relation=%0d", got.relation);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (want.relation <= 2) rel_seen[want.relation]++;
      if (got.relation !== want.relation) begin
        $error("relation: expected %0d, got %0d", want.relation, got.relation);
        errors++;
      end
      if (got.first_x !== want.first_x) begin
        $error("first_x: expected %h, got %h", want.first_x, got.first_x);
        errors++;
      end
      if (got.first_y !== want.first_y) begin
        $error("first_y: expected %h, got %h", want.first_y, got.first_y);
        errors++;
      end
      if (got.second_x !== want.second_x) begin
        $error("second_x: expected %h, got %h", want.second_x, got.second_x);
        errors++;
      end
      if (got.second_y !== want.second_y) begin
        $error("second_y: expected %h, got %h", want.second_y, got.second_y);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sic_seg_if #(.COORD_BITS(CB)) seg_if ();
  sic_res_if res_if ();

  segment_intersection_classifier_top #(.COORD_BITS(CB), .FRAC_BITS(FB)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .seg_i  (seg_if.sink),
    .res_o  (res_if.source)
  );

  always #6 clk_i = ~clk_i;

  verdict_board board = new();

  // Idling phase: 0 none, 1 sender idles, 2 receiver stalls, 3 both.
  int idle_phase = 0;
  bit hold_off = 1'b0;
  bit stim_done = 1'b0;
  int idle_cycles = 0;
  seg_pair_t stim_q[$];

  initial begin
    seg_if.valid = 1'b0;
    {seg_if.p_start_x, seg_if.p_start_y, seg_if.p_end_x, seg_if.p_end_y,
     seg_if.q_start_x, seg_if.q_start_y, seg_if.q_end_x, seg_if.q_end_y} = '0;
    res_if.ready = 1'b0;
  end

  function automatic coord_t rnd_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 40) - 20);
      default: begin
        case ($urandom_range(0, 3))
          0: return coord_t'(16'h8000);
          1: return coord_t'(16'h7fff);
          2: return '0;
          default: return coord_t'(-1);
        endcase
      end
    endcase
  endfunction

  // Random pair shaped toward crossings, parallels and colinear overlaps.
  function automatic seg_pair_t random_pair();
    seg_pair_t s;
    int mode, kind;
    longint bx, by, dx, dy, k0, k1, k2, k3;
    mode = $urandom_range(0, 9) < 5 ? 1 : ($urandom_range(0, 9) < 8 ? 0 : 2);
    kind = $urandom_range(0, 9);
    s.psx = rnd_coord(mode); s.psy = rnd_coord(mode);
    s.pex = rnd_coord(mode); s.pey = rnd_coord(mode);
    s.qsx = rnd_coord(mode); s.qsy = rnd_coord(mode);
    s.qex = rnd_coord(mode); s.qey = rnd_coord(mode);
    if (kind < 3) begin
      // colinear points on one line through a base point
      bx = $signed(rnd_coord(1)); by = $signed(rnd_coord(1));
      dx = longint'($urandom_range(0, 8)) - 4; dy = longint'($urandom_range(0, 8)) - 4;
      k0 = longint'($urandom_range(0, 12)) - 6; k1 = longint'($urandom_range(0, 12)) - 6;
      k2 = longint'($urandom_range(0, 12)) - 6; k3 = longint'($urandom_range(0, 12)) - 6;
      s.psx = coord_t'(bx + k0 * dx); s.psy = coord_t'(by + k0 * dy);
      s.pex = coord_t'(bx + k1 * dx); s.pey = coord_t'(by + k1 * dy);
      s.qsx = coord_t'(bx + k2 * dx); s.qsy = coord_t'(by + k2 * dy);
      s.qex = coord_t'(bx + k3 * dx); s.qey = coord_t'(by + k3 * dy);
    end else if (kind < 4) begin
      // parallel, offset
      s.qex = coord_t'(s.qsx + (s.pex - s.psx));
      s.qey = coord_t'(s.qsy + (s.pey - s.psy));
    end
    return s;
  endfunction

  task automatic add_pair(longint a, longint b, longint c, longint d,
                          longint e, longint f, longint g, longint h);
    seg_pair_t s;
    s = {coord_t'(a), coord_t'(b), coord_t'(c), coord_t'(d),
         coord_t'(e), coord_t'(f), coord_t'(g), coord_t'(h)};
    stim_q.insert(stim_q.size(), s);
  endtask

  task automatic build_directed();
    add_pair(0, 0, 4, 4, 0, 4, 4, 0);               // plain crossing
    add_pair(0, 0, 3, 0, 1, -1, 1, 2);              // crossing at a third
    add_pair(0, 0, 4, 0, 4, 0, 4, 5);               // touching at an end
    add_pair(0, 0, 4, 0, 5, -1, 5, 1);              // miss past the end
    add_pair(0, 0, 4, 0, 0, 1, 4, 1);               // parallel apart
    add_pair(0, 0, 4, 0, 2, 0, 8, 0);               // colinear overlap on x
    add_pair(0, 0, 0, 4, 0, 6, 0, 2);               // colinear overlap, q reversed
    add_pair(0, 0, 2, 0, 2, 0, 5, 0);               // colinear, touch in one point
    add_pair(0, 0, 2, 0, 3, 0, 5, 0);               // colinear, disjoint
    add_pair(1, 1, 3, 3, 2, 2, 2, 2);               // degenerate q
    add_pair(2, 2, 2, 2, 0, 0, 4, 4);               // degenerate p on q
    add_pair(0, 0, 3, 3, -1, -1, 5, 5);             // colinear, equal axes
    add_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    add_pair(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767);
    add_pair(-32768, 0, 32767, 0, -32768, 0, 32767, 0);
    add_pair(-32768, -32768, -32768, 32767, -32768, 0, 32767, 1);
    add_pair(0, 0, 1, 0, 0, 0, 0, 3);               // crossing at the shared start point
    add_pair(0, 0, 3, 1, 1, 1, 2, -1);
    add_pair(-1, -1, -1, -1, -1, -1, -1, -1);       // all degenerate
    add_pair(0, 0, 5, 2, 0, 1, 5, 0);               // crossing that needs rounding
    add_pair(32767, -32768, -32768, 32767, 0, 0, 1, 1);
  endtask

  // Sender gaps: idles 72 percent of the time alone, 31 percent when both sides idle.
  task automatic send_pair(seg_pair_t s);
    while ((idle_phase == 1 && $urandom_range(0, 99) < 72) ||
           (idle_phase == 3 && $urandom_range(0, 99) < 31)) begin
      seg_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    seg_if.valid     <= 1'b1;
    seg_if.p_start_x <= s.psx; seg_if.p_start_y <= s.psy;
    seg_if.p_end_x   <= s.pex; seg_if.p_end_y   <= s.pey;
    seg_if.q_start_x <= s.qsx; seg_if.q_start_y <= s.qsy;
    seg_if.q_end_x   <= s.qex; seg_if.q_end_y   <= s.qey;
    do @(posedge clk_i); while (!seg_if.ready);
    board.note_pair(s);
    @(negedge clk_i);
  endtask

  // Sender: directed part, then random pairs across the idling phases.
  initial begin
    int n;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    build_directed();
    for (int i = 0; i < N_RANDOM; i++) stim_q.insert(stim_q.size(), random_pair());
    n = stim_q.size();
    for (int i = 0; i < n; i++) begin
      idle_phase = (i * 4 / n) % 4;
      if (i == n / 8) hold_off = 1'b1;   // long receiver hold-off while sending
      send_pair(stim_q[i]);
    end
    seg_if.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver ready, changed at the falling edge.
  initial begin
    int hold;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        res_if.ready <= 1'b0;
        for (hold = 0; hold < 3 * LATENCY; hold++) @(negedge clk_i);
        hold_off = 1'b0;
      end
      if (idle_phase == 2) res_if.ready <= ($urandom_range(0, 99) >= 72);
      else if (idle_phase == 3) res_if.ready <= ($urandom_range(0, 99) >= 31);
      else res_if.ready <= 1'b1;
    end
  end

  // Result monitor and watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        board.check_verdict({res_if.relation, res_if.first_x, res_if.first_y,
                             res_if.second_x, res_if.second_y});
        idle_cycles <= 0;
      end else if (seg_if.valid && seg_if.ready) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("watchdog expired with %0d results outstanding", board.pending.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    wait (stim_done);
    wait (board.pending.size() == 0);
    repeat (2 * LATENCY) @(posedge clk_i);
    $display("checked %0d results: %0d no overlap, %0d single point, %0d overlap",
             board.checked, board.rel_seen[0], board.rel_seen[1], board.rel_seen[2]);
    $display("idle phases: none, sender gaps, receiver stalls, both; one long hold-off");
    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
src/sic_pkg.sv
src/sic_seg_if.sv
src/sic_res_if.sv
src/sic_div_cell.sv
src/sic_div_chain.sv
src/segment_intersection_classifier_top.sv
tb/segment_intersection_classifier_top_tb.sv
